[src/square_marker_grid_decode_assert.svh]
// Assertion macros for the square marker grid decoder checks.
// Both sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef SQUARE_MARKER_GRID_DECODE_ASSERT_SVH
`define SQUARE_MARKER_GRID_DECODE_ASSERT_SVH

// Same-cycle implication.
`define SMGD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smgd check failed");

// Delayed implication, with the delay given by dly.
`define SMGD_ASSERT_AFTER(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("smgd check failed");

`endif

[src/smgd_pkg.sv]
// ----------------------------------------------------------------------------
// smgd_pkg
// Shared widths, codeword table, grid helpers and match type for the
// square marker grid decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smgd_pkg;

    localparam int GRID_N    = 7;
    localparam int CELL_W    = GRID_N * GRID_N;
    localparam int ID_W      = 10;
    localparam int TURN_W    = 2;
    localparam int TOL_W     = 3;
    localparam int CW_W      = 5;
    localparam int NUM_CW    = 4;
    localparam int NUM_TURNS = 4;

    localparam logic [TOL_W-1:0] TOL_RESET = 3'd3;

    // Bit k of an entry is the expected cell at column k+1 of an inner row.
    localparam logic [CW_W-1:0] CODEWORDS [NUM_CW] = '{
        5'b00001,
        5'b11101,
        5'b10010,
        5'b01110
    };

    typedef logic [CELL_W-1:0] grid_t;

    typedef struct packed {
        logic            hit;
        logic [ID_W-1:0] id;
    } match_t;

    // Quarter turn: new[i][j] = old[6-j][i].
    function automatic grid_t turn_grid(input grid_t g);
        grid_t t;
        t = '0;
        for (int i = 0; i < GRID_N; i++)
        begin
            for (int j = 0; j < GRID_N; j++)
            begin
                t[GRID_N * i + j] = g[GRID_N * (GRID_N - 1 - j) + i];
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

[src/smgd_border.sv]
// ----------------------------------------------------------------------------
// smgd_border
// Counts border index positions holding any set cell and flags a fault when
// the count exceeds the programmed tolerance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smgd_border
    import smgd_pkg::*;
(
    input  wire grid_t            grid,
    input  wire logic [TOL_W-1:0] tolerance,
    output logic                  fault
);

    logic [GRID_N-1:0] pos_set;
    logic [TOL_W-1:0]  bad_count;

    // Mark each index whose four border cells are not all black
    always_comb
    begin
        for (int i = 0; i < GRID_N; i++)
        begin
            pos_set[i] = grid[GRID_N * i] | grid[GRID_N * i + GRID_N - 1] |
                         grid[i] | grid[GRID_N * (GRID_N - 1) + i];
        end
    end

    // Count marked positions, seven at most
    always_comb
    begin
        bad_count = '0;
        for (int i = 0; i < GRID_N; i++)
        begin
            bad_count = bad_count + {{(TOL_W-1){1'b0}}, pos_set[i]};
        end
    end

    assign fault = (bad_count > tolerance);

endmodule

`default_nettype wire

[src/smgd_row_match.sv]
// ----------------------------------------------------------------------------
// smgd_row_match
// Checks that every inner row of one orientation equals a codeword and
// extracts the 10-bit identifier from that orientation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smgd_row_match
    import smgd_pkg::*;
(
    input  wire grid_t grid,
    output match_t     result
);

    logic [CW_W-1:0] row_bits [1:CW_W];
    logic [CW_W:1]   row_hit;

    // Compare each inner row against the codeword table
    always_comb
    begin
        for (int r = 1; r <= CW_W; r++)
        begin
            row_bits[r] = grid[GRID_N * r + 1 +: CW_W];
            row_hit[r]  = 1'b0;
            for (int w = 0; w < NUM_CW; w++)
            begin
                if (row_bits[r] == CODEWORDS[w])
                begin
                    row_hit[r] = 1'b1;
                end
            end
        end
    end

    // Gather columns 2 and 4 of rows 1 to 5, first row most significant
    always_comb
    begin
        result.hit = &row_hit;
        for (int r = 1; r <= CW_W; r++)
        begin
            result.id[2 * (CW_W - r) + 1] = grid[GRID_N * r + 2];
            result.id[2 * (CW_W - r)]     = grid[GRID_N * r + 4];
        end
    end

endmodule

`default_nettype wire

[src/square_marker_grid_decode.sv]
// ----------------------------------------------------------------------------
// square_marker_grid_decode
// Decodes one sampled 7x7 marker grid per cycle: border check, four
// orientation matches and identifier extraction.
// ----------------------------------------------------------------------------
// A grid request is taken on every clock edge where start is high; busy never
// rises, so one grid per cycle is sustained. The request is registered, decoded
// by one combinational pass (border count plus four fixed-wiring orientation
// matches), and registered again: its result is shown with done high for
// exactly one cycle. The receiver cannot stall the result, so it must
// capture it in that cycle. The border tolerance write port is always
// ready; a new tolerance applies to requests taken at or after the write
// edge.
`timescale 1ns / 1ps
`default_nettype none

module square_marker_grid_decode
    import smgd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [CELL_W-1:0] cell_grid,
    input  wire logic              corners_present,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [TOL_W-1:0]  cfg_data,
    output logic                   done,
    output logic                   marker_valid,
    output logic [ID_W-1:0]        marker_id,
    output logic [TURN_W-1:0]      turns_applied,
    output logic                   border_fault
);

    logic             cfg_write;
    logic [TOL_W-1:0] tolerance_reg;
    logic             req_valid_reg;
    grid_t            grid_reg;
    logic             corners_reg;

    grid_t            turned [NUM_TURNS];
    match_t           match  [NUM_TURNS];
    logic             fault;

    logic              done_next;
    logic              valid_next;
    logic [ID_W-1:0]   id_next;
    logic [TURN_W-1:0] turns_next;
    logic              fault_next;

    logic              done_reg;
    logic              valid_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TURN_W-1:0] turns_reg;
    logic              fault_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    // Hold the border tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= TOL_RESET;
        end
        else if (cfg_write)
        begin
            tolerance_reg <= cfg_data;
        end
    end

    // Capture the incoming request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        grid_reg    <= cell_grid;
        corners_reg <= corners_present;
    end

    // Build the four orientations by fixed wiring
    always_comb
    begin
        turned[0] = grid_reg;
        for (int t = 1; t < NUM_TURNS; t++)
        begin
            turned[t] = turn_grid(turned[t-1]);
        end
    end

    smgd_border u_border (
        .grid      (grid_reg),
        .tolerance (tolerance_reg),
        .fault     (fault)
    );

    genvar gt;
    generate
        for (gt = 0; gt < NUM_TURNS; gt++)
        begin : g_turn
            smgd_row_match u_match (
                .grid   (turned[gt]),
                .result (match[gt])
            );
        end
    endgenerate

    // Select the first matching orientation and apply the special cases
    always_comb
    begin
        done_next  = req_valid_reg;
        valid_next = 1'b0;
        id_next    = '0;
        turns_next = '0;
        fault_next = 1'b0;
        if (req_valid_reg && corners_reg)
        begin
            if (fault)
            begin
                fault_next = 1'b1;
            end
            else
            begin
                for (int t = NUM_TURNS - 1; t >= 0; t--)
                begin
                    if (match[t].hit)
                    begin
                        valid_next = 1'b1;
                        id_next    = match[t].id;
                        turns_next = TURN_W'(t);
                    end
                end
            end
        end
    end

    // Advance the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        valid_reg <= valid_next;
        id_reg    <= id_next;
        turns_reg <= turns_next;
        fault_reg <= fault_next;
    end

    assign done          = done_reg;
    assign marker_valid  = valid_reg;
    assign marker_id     = id_reg;
    assign turns_applied = turns_reg;
    assign border_fault  = fault_reg;

endmodule

`default_nettype wire

[src/smgd_checker.sv]
// ----------------------------------------------------------------------------
// smgd_checker
// Port-level checks on the square marker grid decoder: result timing and
// consistency of the result fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "square_marker_grid_decode_assert.svh"

module smgd_checker
    import smgd_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire logic              marker_valid,
    input wire logic [ID_W-1:0]   marker_id,
    input wire logic [TURN_W-1:0] turns_applied,
    input wire logic              border_fault
);

    // Every request yields a result with done high
    `SMGD_ASSERT_AFTER(a_req_to_done, start && !busy && $past(rst_n), 2, done)

    // A decoded marker never comes with a border fault
    `SMGD_ASSERT_NOW(a_valid_no_fault, marker_valid, done && !border_fault)

    // Without a decode, identifier and turn count read zero
    `SMGD_ASSERT_NOW(a_invalid_zero, done && !marker_valid,
                     marker_id == '0 && turns_applied == '0)

    // Outside the result cycle all flags are low
    `SMGD_ASSERT_NOW(a_idle_quiet, !done, !marker_valid && !border_fault)

endmodule

bind square_marker_grid_decode smgd_checker u_smgd_checker (.*);

`default_nettype wire
